@@ rtl/core/piqe_pkg.sv @@
package piqe_pkg;

  localparam int PC_W      = 5;
  localparam int FRAC_W    = 16;
  localparam int DIV_STEPS = FRAC_W;

  localparam logic [15:0] ROT_RATE_RESET = 16'd6554;

  typedef logic [PC_W-1:0] pc_t;

  typedef enum logic [1:0] {
    CMD_SPAWN = 2'd0,
    CMD_TICK  = 2'd1,
    CMD_EMIT  = 2'd2,
    CMD_NOP   = 2'd3
  } cmd_t;

  typedef struct packed {
    cmd_t               cmd;
    logic signed [31:0] spawn_pos_x;
    logic signed [31:0] spawn_pos_y;
    logic signed [31:0] spawn_vel_x;
    logic signed [31:0] spawn_vel_y;
    logic        [31:0] spawn_color_begin;
    logic        [31:0] spawn_color_final;
    logic signed [31:0] spawn_angle;
    logic        [15:0] spawn_size_begin;
    logic        [15:0] spawn_size_final;
    logic        [23:0] spawn_life;
    logic        [23:0] time_step;
  } in_word_t;

  typedef struct packed {
    logic signed [31:0] vert_x;
    logic signed [31:0] vert_y;
    logic signed [31:0] vert_angle;
    logic        [15:0] vert_size;
    logic        [7:0]  red;
    logic        [7:0]  green;
    logic        [7:0]  blue;
    logic        [7:0]  alpha;
    logic               alive;
    logic               last;
  } out_word_t;

  // multiplier operand select
  typedef enum logic [3:0] {
    MS_NONE, MS_VX, MS_VY, MS_ROT, MS_SIZE, MS_RED, MS_GREEN, MS_BLUE, MS_ALPHA
  } mul_src_t;

  // product writeback
  typedef enum logic [3:0] {
    WB_NONE, WB_POSX, WB_POSY, WB_ANGLE, WB_SIZE, WB_RED, WB_GREEN, WB_BLUE, WB_ALPHA
  } wb_t;

  typedef enum logic [2:0] {
    ACT_NONE, ACT_LOAD, ACT_LIFE, ACT_KILL, ACT_DIV_INIT, ACT_DIV_STEP
  } act_t;

  typedef enum logic [2:0] {
    OS_NONE, OS_SIMPLE, OS_BL, OS_BR, OS_TR, OS_TL
  } osel_t;

  typedef enum logic [2:0] {
    J_NEXT, J_GOTO, J_END, J_KILL, J_DEAD, J_DIV
  } jmp_t;

  typedef struct packed {
    mul_src_t mul;
    wb_t      wb;
    act_t     act;
    osel_t    osel;
    jmp_t     jmp;
    pc_t      target;
  } uword_t;

  typedef struct packed {
    logic kill;
    logic dead;
    logic div_more;
    logic out_free;
  } cond_t;

  localparam pc_t PC_SPAWN  = 5'd0;
  localparam pc_t PC_SIMPLE = 5'd1;
  localparam pc_t PC_TICK   = 5'd2;
  localparam pc_t PC_KILL   = 5'd6;
  localparam pc_t PC_EMIT   = 5'd7;
  localparam pc_t PC_DIV    = 5'd8;
  localparam pc_t PC_CORNER = 5'd15;

  function automatic pc_t entry(input cmd_t c);
    pc_t p;
    unique case (c)
      CMD_SPAWN: p = PC_SPAWN;
      CMD_TICK:  p = PC_TICK;
      CMD_EMIT:  p = PC_EMIT;
      default:   p = PC_SIMPLE;
    endcase
    return p;
  endfunction

  function automatic uword_t urom(input pc_t pc);
    uword_t uw;
    uw.mul    = MS_NONE;
    uw.wb     = WB_NONE;
    uw.act    = ACT_NONE;
    uw.osel   = OS_NONE;
    uw.jmp    = J_NEXT;
    uw.target = '0;
    unique case (pc)
      5'd0:  uw.act = ACT_LOAD;
      5'd1:  begin uw.osel = OS_SIMPLE; uw.jmp = J_END; end
      5'd2:  begin uw.mul = MS_VX; uw.jmp = J_KILL; uw.target = PC_KILL; end
      5'd3:  begin uw.mul = MS_VY; uw.wb = WB_POSX; uw.act = ACT_LIFE; end
      5'd4:  begin uw.mul = MS_ROT; uw.wb = WB_POSY; end
      5'd5:  begin uw.wb = WB_ANGLE; uw.jmp = J_GOTO; uw.target = PC_SIMPLE; end
      5'd6:  begin uw.act = ACT_KILL; uw.jmp = J_GOTO; uw.target = PC_SIMPLE; end
      5'd7:  begin uw.act = ACT_DIV_INIT; uw.jmp = J_DEAD; uw.target = PC_CORNER; end
      5'd8:  begin uw.act = ACT_DIV_STEP; uw.jmp = J_DIV; uw.target = PC_DIV; end
      5'd9:  uw.mul = MS_SIZE;
      5'd10: begin uw.mul = MS_RED;   uw.wb = WB_SIZE;  end
      5'd11: begin uw.mul = MS_GREEN; uw.wb = WB_RED;   end
      5'd12: begin uw.mul = MS_BLUE;  uw.wb = WB_GREEN; end
      5'd13: begin uw.mul = MS_ALPHA; uw.wb = WB_BLUE;  end
      5'd14: uw.wb = WB_ALPHA;
      5'd15: uw.osel = OS_BL;
      5'd16: uw.osel = OS_BR;
      5'd17: uw.osel = OS_TR;
      5'd18: begin uw.osel = OS_TL; uw.jmp = J_END; end
      default: uw.jmp = J_END;
    endcase
    return uw;
  endfunction

endpackage

@@ rtl/core/piqe_seq.sv @@
module piqe_seq (
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  input  piqe_pkg::cmd_t    cmd,
  input  piqe_pkg::cond_t   cond,
  output logic              busy,
  output logic              fire,
  output piqe_pkg::uword_t  uw
);

  piqe_pkg::pc_t pc, pc_next;
  logic          busy_next;

  assign uw   = piqe_pkg::urom(pc);
  assign fire = busy && (uw.osel == piqe_pkg::OS_NONE || cond.out_free);

  always_comb begin
    pc_next   = pc;
    busy_next = busy;
    if (start) begin
      pc_next   = piqe_pkg::entry(cmd);
      busy_next = 1'b1;
    end else if (fire) begin
      unique case (uw.jmp)
        piqe_pkg::J_NEXT: pc_next = pc + 1'b1;
        piqe_pkg::J_GOTO: pc_next = uw.target;
        piqe_pkg::J_END:  busy_next = 1'b0;
        piqe_pkg::J_KILL: pc_next = cond.kill ? uw.target : pc + 1'b1;
        piqe_pkg::J_DEAD: pc_next = cond.dead ? uw.target : pc + 1'b1;
        piqe_pkg::J_DIV:  pc_next = cond.div_more ? uw.target : pc + 1'b1;
        default:          busy_next = 1'b0;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pc   <= '0;
      busy <= 1'b0;
    end else begin
      pc   <= pc_next;
      busy <= busy_next;
    end
  end

endmodule

@@ rtl/core/particle_integrate_and_quad_emit.sv @@
// channel  direction  handshake           payload
// in       in         in_valid/in_stall   in_data   (piqe_pkg::in_word_t)
// out      out        out_valid/out_stall out_data  (piqe_pkg::out_word_t)
// cfg      in         cfg_we              cfg_data  (rotation rate, Q0.16)
//
// One word at a time; in_stall is high while the microprogram runs.
// Spawn loads and tick kills or integrates, each then writing one result word.
// Emit runs the 17 passes of the bit-serial life divider and the five blends
// through the one shared multiplier, then four corners; inactive, it skips both.
// Synchronous reset marks the particle inactive and loads the default rotation rate.
// A stalled output holds the program at its next result step.
module particle_integrate_and_quad_emit (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  piqe_pkg::in_word_t   in_data,
  output logic                 out_valid,
  input  logic                 out_stall,
  output piqe_pkg::out_word_t  out_data,
  input  logic                 cfg_we,
  input  logic [15:0]          cfg_data
);

  logic               start, busy, fire;
  piqe_pkg::uword_t   uw;
  piqe_pkg::cond_t    cond;
  piqe_pkg::in_word_t in_q;

  logic [15:0]        rotation_rate;

  logic signed [31:0] position_x, position_y, velocity_x, velocity_y, angle;
  logic [31:0]        color_birth, color_death;
  logic [15:0]        size_birth, size_death;
  logic [23:0]        life_total, life_left;
  logic               is_active;

  logic [24:0]        rem;
  logic [16:0]        quot;
  logic [4:0]         div_cnt;
  logic [25:0]        trial;
  logic               qbit;
  logic [24:0]        rem_sel;
  logic [16:0]        f_val;

  logic signed [32:0] mul_a;
  logic signed [24:0] mul_b;
  logic signed [57:0] prod;
  logic [15:0]        death_sel;
  logic [33:0]        blend_sum;

  logic [15:0]        size_q;
  logic [7:0]         red_q, green_q, blue_q, alpha_q;

  logic [31:0]        half;
  logic               out_free;
  piqe_pkg::out_word_t out_next;

  assign start    = in_valid && !in_stall;
  assign in_stall = busy;
  assign out_free = !out_valid || !out_stall;

  assign cond.kill     = !is_active || (in_q.time_step >= life_left);
  assign cond.dead     = !is_active;
  assign cond.div_more = (div_cnt != '0);
  assign cond.out_free = out_free;

  piqe_seq u_seq (
    .clk   (clk),
    .rst   (rst),
    .start (start),
    .cmd   (in_data.cmd),
    .cond  (cond),
    .busy  (busy),
    .fire  (fire),
    .uw    (uw)
  );

  always_ff @(posedge clk) begin
    if (start) in_q <= in_data;
  end

  always_ff @(posedge clk) begin
    if (rst) rotation_rate <= piqe_pkg::ROT_RATE_RESET;
    else if (cfg_we) rotation_rate <= cfg_data;
  end

  // restoring divide: life_left / life_total as Q1.16
  assign trial   = {1'b0, rem} - {2'b00, life_total};
  assign qbit    = !trial[25];
  assign rem_sel = qbit ? trial[24:0] : rem;
  assign f_val   = (life_total == '0) ? '0 : quot;

  always_ff @(posedge clk) begin
    if (fire && uw.act == piqe_pkg::ACT_DIV_INIT) begin
      rem     <= {1'b0, life_left};
      quot    <= '0;
      div_cnt <= 5'(piqe_pkg::DIV_STEPS);
    end else if (fire && uw.act == piqe_pkg::ACT_DIV_STEP) begin
      rem     <= {rem_sel[23:0], 1'b0};
      quot    <= {quot[15:0], qbit};
      div_cnt <= div_cnt - 1'b1;
    end
  end

  // shared multiplier; blend uses death + (birth - death) * f
  always_comb begin
    mul_a = '0;
    mul_b = $signed({1'b0, in_q.time_step});
    case (uw.mul)
      piqe_pkg::MS_VX:  mul_a = 33'(velocity_x);
      piqe_pkg::MS_VY:  mul_a = 33'(velocity_y);
      piqe_pkg::MS_ROT: mul_a = $signed({17'b0, rotation_rate});
      piqe_pkg::MS_SIZE: begin
        mul_a = 33'($signed({1'b0, size_birth} - {1'b0, size_death}));
        mul_b = $signed({8'b0, f_val});
      end
      piqe_pkg::MS_RED: begin
        mul_a = 33'($signed({1'b0, color_birth[31:24]} - {1'b0, color_death[31:24]}));
        mul_b = $signed({8'b0, f_val});
      end
      piqe_pkg::MS_GREEN: begin
        mul_a = 33'($signed({1'b0, color_birth[23:16]} - {1'b0, color_death[23:16]}));
        mul_b = $signed({8'b0, f_val});
      end
      piqe_pkg::MS_BLUE: begin
        mul_a = 33'($signed({1'b0, color_birth[15:8]} - {1'b0, color_death[15:8]}));
        mul_b = $signed({8'b0, f_val});
      end
      piqe_pkg::MS_ALPHA: begin
        mul_a = 33'($signed({1'b0, color_birth[7:0]} - {1'b0, color_death[7:0]}));
        mul_b = $signed({8'b0, f_val});
      end
      default: mul_a = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (fire) prod <= mul_a * mul_b;
  end

  always_comb begin
    case (uw.wb)
      piqe_pkg::WB_SIZE:  death_sel = size_death;
      piqe_pkg::WB_RED:   death_sel = {8'b0, color_death[31:24]};
      piqe_pkg::WB_GREEN: death_sel = {8'b0, color_death[23:16]};
      piqe_pkg::WB_BLUE:  death_sel = {8'b0, color_death[15:8]};
      default:            death_sel = {8'b0, color_death[7:0]};
    endcase
  end

  assign blend_sum = {2'b00, death_sel, 16'h0000} + prod[33:0] + 34'd32768;

  always_ff @(posedge clk) begin
    if (fire) begin
      case (uw.wb)
        piqe_pkg::WB_SIZE:  size_q  <= blend_sum[31:16];
        piqe_pkg::WB_RED:   red_q   <= blend_sum[23:16];
        piqe_pkg::WB_GREEN: green_q <= blend_sum[23:16];
        piqe_pkg::WB_BLUE:  blue_q  <= blend_sum[23:16];
        piqe_pkg::WB_ALPHA: alpha_q <= blend_sum[23:16];
        default: ;
      endcase
    end
  end

  // particle state
  always_ff @(posedge clk) begin
    if (fire) begin
      case (uw.wb)
        piqe_pkg::WB_POSX:  position_x <= position_x + prod[47:16];
        piqe_pkg::WB_POSY:  position_y <= position_y + prod[47:16];
        piqe_pkg::WB_ANGLE: angle      <= angle + prod[47:16];
        default: ;
      endcase
      case (uw.act)
        piqe_pkg::ACT_LOAD: begin
          position_x  <= in_q.spawn_pos_x;
          position_y  <= in_q.spawn_pos_y;
          velocity_x  <= in_q.spawn_vel_x;
          velocity_y  <= in_q.spawn_vel_y;
          color_birth <= in_q.spawn_color_begin;
          color_death <= in_q.spawn_color_final;
          angle       <= in_q.spawn_angle;
          size_birth  <= in_q.spawn_size_begin;
          size_death  <= in_q.spawn_size_final;
          life_total  <= in_q.spawn_life;
          life_left   <= in_q.spawn_life;
        end
        piqe_pkg::ACT_LIFE: life_left <= life_left - in_q.time_step;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      is_active <= 1'b0;
    end else if (fire) begin
      if (uw.act == piqe_pkg::ACT_LOAD) is_active <= 1'b1;
      else if (uw.act == piqe_pkg::ACT_KILL) is_active <= 1'b0;
    end
  end

  // result word
  assign half = {9'b0, size_q, 7'b0};

  always_comb begin
    out_next = '0;
    case (uw.osel) inside
      piqe_pkg::OS_SIMPLE: begin
        out_next.alive = is_active;
        out_next.last  = 1'b1;
      end
      piqe_pkg::OS_BL, piqe_pkg::OS_BR, piqe_pkg::OS_TR, piqe_pkg::OS_TL: begin
        out_next.last = (uw.osel == piqe_pkg::OS_TL);
        if (is_active) begin
          out_next.vert_x = (uw.osel == piqe_pkg::OS_BL || uw.osel == piqe_pkg::OS_TL) ?
                            position_x - half : position_x + half;
          out_next.vert_y = (uw.osel == piqe_pkg::OS_BL || uw.osel == piqe_pkg::OS_BR) ?
                            position_y - half : position_y + half;
          out_next.vert_angle = angle;
          out_next.vert_size  = size_q;
          out_next.red        = red_q;
          out_next.green      = green_q;
          out_next.blue       = blue_q;
          out_next.alpha      = alpha_q;
          out_next.alive      = 1'b1;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (fire && uw.osel != piqe_pkg::OS_NONE) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (fire && uw.osel != piqe_pkg::OS_NONE) out_data <= out_next;
  end

endmodule

@@ sim/tb_top.sv @@
`timescale 1ns / 1ps

module tb_top;

  localparam int IDLE_LIMIT = 2000;

  logic                clk = 1'b0;
  logic                rst;
  logic                in_valid;
  logic                in_stall;
  piqe_pkg::in_word_t  in_data;
  logic                out_valid;
  logic                out_stall;
  piqe_pkg::out_word_t out_data;
  logic                cfg_we;
  logic [15:0]         cfg_data;

  particle_integrate_and_quad_emit dut (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .cfg_we    (cfg_we),
    .cfg_data  (cfg_data)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // predicted particle
  logic [15:0] rot_rate;
  logic [31:0] pos_x, pos_y, vel_x, vel_y, col_b, col_d, ang;
  logic [15:0] sz_b, sz_d;
  logic [23:0] life_tot, life_rem;
  logic        active;

  piqe_pkg::out_word_t expected_verts [$];
  piqe_pkg::out_word_t want;
  int                  mismatches;
  int                  idle_cycles;
  int                  in_gap_max;
  int                  out_gap_max;
  int                  rx_hold;
  int                  rx_wait;
  bit                  typed_pending;
  piqe_pkg::out_word_t typed_word;

  typedef struct {
    piqe_pkg::in_word_t  w;
    bit                  typed;
    piqe_pkg::out_word_t res;
  } dir_row_t;

  dir_row_t dir_tab [$];

  task automatic clear_particle();
    pos_x = '0; pos_y = '0; vel_x = '0; vel_y = '0;
    col_b = '0; col_d = '0; ang = '0;
    sz_b = '0; sz_d = '0;
    life_tot = '0; life_rem = '0;
    active = 1'b0;
  endtask

  // signed velocity times step, floor shift by 16
  function automatic logic [31:0] vel_step(logic [31:0] v, logic [23:0] dt);
    logic signed [63:0] p;
    p = $signed({{32{v[31]}}, v}) * $signed({40'd0, dt});
    return p[47:16];
  endfunction

  function automatic logic [15:0] blend(logic [15:0] d, logic [15:0] b, logic [16:0] f);
    logic [63:0] s;
    s = {48'd0, d} * (64'd65536 - {47'd0, f}) + {48'd0, b} * {47'd0, f} + 64'd32768;
    return s[31:16];
  endfunction

  task automatic integrate_and_emit(input piqe_pkg::in_word_t w);
    piqe_pkg::out_word_t o;
    logic [63:0]         q;
    logic [63:0]         prod;
    logic [16:0]         frac;
    logic [15:0]         sz;
    logic [15:0]         ch [4];
    logic [31:0]         half;
    int                  k;
    case (w.cmd)
      piqe_pkg::CMD_SPAWN: begin
        pos_x = w.spawn_pos_x; pos_y = w.spawn_pos_y;
        vel_x = w.spawn_vel_x; vel_y = w.spawn_vel_y;
        col_b = w.spawn_color_begin; col_d = w.spawn_color_final;
        ang = w.spawn_angle;
        sz_b = w.spawn_size_begin; sz_d = w.spawn_size_final;
        life_tot = w.spawn_life; life_rem = w.spawn_life;
        active = 1'b1;
      end
      piqe_pkg::CMD_TICK: begin
        if (w.time_step >= life_rem) begin
          clear_particle();
        end else begin
          life_rem = life_rem - w.time_step;
          pos_x = pos_x + vel_step(vel_x, w.time_step);
          pos_y = pos_y + vel_step(vel_y, w.time_step);
          prod = {48'd0, rot_rate} * {40'd0, w.time_step};
          ang = ang + prod[47:16];
        end
      end
      piqe_pkg::CMD_EMIT: begin
        if (!active) begin
          for (k = 0; k < 4; k++) begin
            o = '0;
            o.last = (k == 3);
            expected_verts.push_back(o);
          end
        end else begin
          frac = '0;
          if (life_tot != 0) begin
            q = {24'd0, life_rem, 16'd0} / {40'd0, life_tot};
            frac = (q > 64'd65536) ? 17'h10000 : q[16:0];
          end
          sz = blend(sz_d, sz_b, frac);
          for (k = 0; k < 4; k++)
            ch[k] = blend({8'd0, col_d[31-8*k -: 8]}, {8'd0, col_b[31-8*k -: 8]}, frac);
          half = {9'd0, sz, 7'd0};
          // bottom-left, bottom-right, top-right, top-left
          for (k = 0; k < 4; k++) begin
            o = '0;
            o.vert_x     = (k == 0 || k == 3) ? pos_x - half : pos_x + half;
            o.vert_y     = (k < 2) ? pos_y - half : pos_y + half;
            o.vert_angle = ang;
            o.vert_size  = sz;
            o.red        = ch[0][7:0];
            o.green      = ch[1][7:0];
            o.blue       = ch[2][7:0];
            o.alpha      = ch[3][7:0];
            o.alive      = 1'b1;
            o.last       = (k == 3);
            expected_verts.push_back(o);
          end
        end
      end
      default: ;
    endcase
    if (w.cmd != piqe_pkg::CMD_EMIT) begin
      o = '0;
      o.alive = active;
      o.last  = 1'b1;
      expected_verts.push_back(o);
    end
  endtask

  task automatic check_field(input string name, input logic [31:0] e, input logic [31:0] a);
    if (e !== a) begin
      $display("%0t: %s expected %h got %h", $time, name, e, a);
      mismatches++;
    end
  endtask

  always @(posedge clk) begin
    if (!rst) begin
      if (out_valid && !out_stall) begin
        if (expected_verts.size() == 0) begin
          $display("%0t: unexpected word %h", $time, out_data);
          mismatches++;
        end else begin
          want = expected_verts.pop_front();
          check_field("vert_x", want.vert_x, out_data.vert_x);
          check_field("vert_y", want.vert_y, out_data.vert_y);
          check_field("vert_angle", want.vert_angle, out_data.vert_angle);
          check_field("vert_size", 32'(want.vert_size), 32'(out_data.vert_size));
          check_field("red", 32'(want.red), 32'(out_data.red));
          check_field("green", 32'(want.green), 32'(out_data.green));
          check_field("blue", 32'(want.blue), 32'(out_data.blue));
          check_field("alpha", 32'(want.alpha), 32'(out_data.alpha));
          check_field("alive", 32'(want.alive), 32'(out_data.alive));
          check_field("last", 32'(want.last), 32'(out_data.last));
        end
      end
      if (in_valid && !in_stall) begin
        integrate_and_emit(in_data);
        if (typed_pending) begin
          expected_verts[expected_verts.size()-1] = typed_word;
          typed_pending = 1'b0;
        end
      end
    end
  end

  always @(posedge clk) begin
    if (rst || (in_valid && !in_stall) || (out_valid && !out_stall))
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("tb_top: FAIL");
      $finish;
    end
  end

  // result side: random or long hold-off before each word
  always begin
    @(negedge clk);
    if (rx_hold != 0)
      rx_wait = rx_hold;
    else
      rx_wait = (out_gap_max > 0) ? $urandom_range(0, out_gap_max) : 0;
    rx_hold = 0;
    if (rx_wait != 0) begin
      out_stall = 1'b1;
      repeat (rx_wait) @(negedge clk);
    end
    out_stall = 1'b0;
    do @(posedge clk); while (!(out_valid && !rst));
  end

  task automatic send_word(input piqe_pkg::in_word_t w, input bit typed,
                           input piqe_pkg::out_word_t r);
    int gap;
    gap = (in_gap_max > 0) ? $urandom_range(0, in_gap_max) : 0;
    @(negedge clk);
    if (gap != 0) begin
      in_valid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    typed_pending = typed;
    typed_word    = r;
    in_data       = w;
    in_valid      = 1'b1;
    do @(posedge clk); while (in_stall);
  endtask

  task automatic quiesce();
    @(negedge clk);
    in_valid = 1'b0;
    while (expected_verts.size() != 0) @(posedge clk);
  endtask

  task automatic set_rate(input logic [15:0] v);
    quiesce();
    repeat (8) @(negedge clk);
    cfg_data = v;
    cfg_we   = 1'b1;
    rot_rate = v;
    @(negedge clk);
    cfg_we = 1'b0;
  endtask

  function automatic piqe_pkg::in_word_t mk_spawn(logic [31:0] px, py, vx, vy, cb, cf, an,
                                                  logic [15:0] sb, sf, logic [23:0] lf);
    piqe_pkg::in_word_t w;
    w = '0;
    w.cmd = piqe_pkg::CMD_SPAWN;
    w.spawn_pos_x = px; w.spawn_pos_y = py;
    w.spawn_vel_x = vx; w.spawn_vel_y = vy;
    w.spawn_color_begin = cb; w.spawn_color_final = cf;
    w.spawn_angle = an;
    w.spawn_size_begin = sb; w.spawn_size_final = sf;
    w.spawn_life = lf;
    return w;
  endfunction

  function automatic piqe_pkg::in_word_t mk_op(piqe_pkg::cmd_t c, logic [23:0] dt);
    piqe_pkg::in_word_t w;
    w = '0;
    w.cmd = c;
    w.time_step = dt;
    return w;
  endfunction

  function automatic piqe_pkg::out_word_t simple_word(bit alive);
    piqe_pkg::out_word_t o;
    o = '0;
    o.alive = alive;
    o.last  = 1'b1;
    return o;
  endfunction

  function automatic piqe_pkg::in_word_t noise_word();
    piqe_pkg::in_word_t w;
    w.cmd = piqe_pkg::cmd_t'($urandom_range(0, 3));
    w.spawn_pos_x = $urandom; w.spawn_pos_y = $urandom;
    w.spawn_vel_x = $urandom; w.spawn_vel_y = $urandom;
    w.spawn_color_begin = $urandom; w.spawn_color_final = $urandom;
    w.spawn_angle = $urandom;
    w.spawn_size_begin = 16'($urandom); w.spawn_size_final = 16'($urandom);
    w.spawn_life = 24'($urandom);
    w.time_step = 24'($urandom);
    return w;
  endfunction

  task automatic add_row(input piqe_pkg::in_word_t w, input bit typed,
                         input piqe_pkg::out_word_t r);
    dir_row_t row;
    row.w = w;
    row.typed = typed;
    row.res = r;
    dir_tab.push_back(row);
  endtask

  // mostly spawn then a run of ticks and emits; the rest is noise
  task automatic run_random(input int n);
    piqe_pkg::in_word_t w;
    int                 sent;
    logic [23:0]        life;
    sent = 0;
    while (sent < n) begin
      if ($urandom_range(0, 99) < 80) begin
        w = noise_word();
        w.cmd = piqe_pkg::CMD_SPAWN;
        if ($urandom_range(0, 3) == 0) w.spawn_life = 24'($urandom_range(1, 255));
        life = w.spawn_life;
        send_word(w, 1'b0, '0);
        sent++;
        repeat ($urandom_range(2, 8)) begin
          w = noise_word();
          if ($urandom_range(0, 9) < 6) begin
            w.cmd = piqe_pkg::CMD_EMIT;
          end else begin
            w.cmd = piqe_pkg::CMD_TICK;
            if ($urandom_range(0, 9) != 0) w.time_step = 24'($urandom_range(0, life / 4));
          end
          send_word(w, 1'b0, '0);
          sent++;
        end
      end else begin
        send_word(noise_word(), 1'b0, '0);
        sent++;
      end
    end
  endtask

  initial begin
    int          p;
    logic [15:0] r;
    rst = 1'b1;
    in_valid = 1'b0;
    in_data = '0;
    out_stall = 1'b0;
    cfg_we = 1'b0;
    cfg_data = '0;
    in_gap_max = 13;
    out_gap_max = 13;
    rx_hold = 0;
    mismatches = 0;
    idle_cycles = 0;
    typed_pending = 1'b0;
    typed_word = '0;
    rot_rate = piqe_pkg::ROT_RATE_RESET;
    clear_particle();

    add_row(mk_op(piqe_pkg::CMD_TICK, 24'h000000), 1'b1, simple_word(1'b0));
    add_row(mk_op(piqe_pkg::CMD_EMIT, 24'h000000), 1'b0, '0);
    add_row(mk_op(piqe_pkg::CMD_NOP, 24'hFFFFFF), 1'b1, simple_word(1'b0));
    add_row(mk_spawn(32'h7FFFFFFF, 32'h80000000, 32'h80000000, 32'h7FFFFFFF,
                     32'hFFFFFFFF, 32'h00000000, 32'h7FFFFFFF, 16'hFFFF, 16'h0000,
                     24'hFFFFFF), 1'b1, simple_word(1'b1));
    add_row(mk_op(piqe_pkg::CMD_EMIT, 24'h000000), 1'b0, '0);
    add_row(mk_op(piqe_pkg::CMD_TICK, 24'h000001), 1'b0, '0);
    add_row(mk_op(piqe_pkg::CMD_TICK, 24'h7FFFFF), 1'b0, '0);
    add_row(mk_op(piqe_pkg::CMD_EMIT, 24'h000000), 1'b0, '0);
    add_row(mk_op(piqe_pkg::CMD_NOP, 24'h000000), 1'b1, simple_word(1'b1));
    add_row(mk_op(piqe_pkg::CMD_TICK, 24'hFFFFFF), 1'b1, simple_word(1'b0));
    add_row(mk_op(piqe_pkg::CMD_EMIT, 24'h000000), 1'b0, '0);
    // zero lifetime: death values
    add_row(mk_spawn(32'h00000000, 32'h00000000, 32'h00000000, 32'h00000000,
                     32'h00000000, 32'hFFFFFFFF, 32'h80000000, 16'h0000, 16'hFFFF,
                     24'h000000), 1'b1, simple_word(1'b1));
    add_row(mk_op(piqe_pkg::CMD_EMIT, 24'h000000), 1'b0, '0);
    add_row(mk_op(piqe_pkg::CMD_TICK, 24'h000000), 1'b1, simple_word(1'b0));
    add_row(mk_spawn(32'hFFFF0000, 32'hFFFE8000, 32'hFFFFFFFF, 32'h80000000,
                     32'h12345678, 32'h9ABCDEF0, 32'h00000000, 16'h0100, 16'h0200,
                     24'h000001), 1'b1, simple_word(1'b1));
    add_row(mk_op(piqe_pkg::CMD_TICK, 24'h000000), 1'b0, '0);
    add_row(mk_op(piqe_pkg::CMD_EMIT, 24'h000000), 1'b0, '0);
    add_row(mk_op(piqe_pkg::CMD_TICK, 24'h000001), 1'b1, simple_word(1'b0));
    add_row(mk_spawn(32'h00010000, 32'hFFFF0000, 32'hFFFF8000, 32'h00020000,
                     32'h11223344, 32'h55667788, 32'h00001000, 16'h0800, 16'h0400,
                     24'h010000), 1'b1, simple_word(1'b1));
    add_row(mk_op(piqe_pkg::CMD_TICK, 24'h004000), 1'b0, '0);
    add_row(mk_op(piqe_pkg::CMD_EMIT, 24'h000000), 1'b0, '0);
    // respawn over a live particle
    add_row(mk_spawn(32'hC0000000, 32'h3FFFFFFF, 32'h00000001, 32'hFFFFFFFF,
                     32'h00FF00FF, 32'hFF00FF00, 32'h80000000, 16'h0001, 16'hFFFF,
                     24'h800000), 1'b1, simple_word(1'b1));
    add_row(mk_op(piqe_pkg::CMD_EMIT, 24'h000000), 1'b0, '0);

    repeat (12) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    foreach (dir_tab[i]) send_word(dir_tab[i].w, dir_tab[i].typed, dir_tab[i].res);

    for (p = 0; p < 5; p++) begin
      case (p)
        0: r = 16'hFFFF;
        1: r = 16'h0000;
        2: r = 16'($urandom_range(2, 65534));
        3: r = 16'h0001;
        default: r = piqe_pkg::ROT_RATE_RESET;
      endcase
      set_rate(r);
      in_gap_max  = (p == 1 || p == 3) ? 0 : 13;
      out_gap_max = (p == 1 || p == 2) ? 0 : 13;
      if (p == 1) begin
        run_random(36);
        rx_hold = 220;
        run_random(36);
      end else if (p == 2) begin
        run_random(36);
        quiesce();
        run_random(36);
      end else begin
        run_random(72);
      end
    end

    quiesce();
    repeat (40) @(posedge clk);
    if (mismatches == 0)
      $display("tb_top: PASS");
    else
      $display("tb_top: FAIL");
    $finish;
  end

endmodule
